/* rtl/y86bsd_pkg.sv */
// Shared types and constants for the Y86 byte-stream decoder.
// Used by every module in rtl/; depends on nothing else.
`default_nettype none

package y86bsd_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned LEN_W   = 3;

  // Y86 instruction codes (upper nibble of the opcode byte).
  localparam logic [3:0] IC_HALT  = 4'h0;
  localparam logic [3:0] IC_NOP   = 4'h1;
  localparam logic [3:0] IC_CMOV  = 4'h2;
  localparam logic [3:0] IC_IRMOV = 4'h3;
  localparam logic [3:0] IC_RMMOV = 4'h4;
  localparam logic [3:0] IC_MRMOV = 4'h5;
  localparam logic [3:0] IC_OP    = 4'h6;
  localparam logic [3:0] IC_JXX   = 4'h7;
  localparam logic [3:0] IC_CALL  = 4'h8;
  localparam logic [3:0] IC_RET   = 4'h9;
  localparam logic [3:0] IC_PUSH  = 4'hA;
  localparam logic [3:0] IC_POP   = 4'hB;
  localparam logic [3:0] IC_FIRST_BAD = 4'hC;

  // Highest function code accepted for cmov, OP and jXX.
  localparam logic [3:0] FUN_MAX  = 4'h6;
  // Register nibble pair used when an instruction has no register byte.
  localparam logic [7:0] REG_NONE = 8'hFF;

  // One decoded instruction.
  typedef struct packed {
    logic              is_valid;
    logic [LEN_W-1:0]  instr_length;
    logic [WORD_W-1:0] constant_word;
    logic [3:0]        reg_b;
    logic [3:0]        reg_a;
    logic [3:0]        ifun;
    logic [3:0]        icode;
    logic [ADDR_W-1:0] instr_address;
  } rec_t;

endpackage

`default_nettype wire

/* rtl/y86bsd_assembler.sv */
// Instruction assembly state and record formation for the Y86 decoder.
// Depends on y86bsd_pkg.
`default_nettype none

module y86bsd_assembler
  import y86bsd_pkg::*;
#(
  parameter int unsigned CONST_BYTES = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire logic [7:0]        byte_i,
  input  wire logic              last_i,
  input  wire logic              cfg_we_i,
  input  wire logic [ADDR_W-1:0] cfg_data_i,
  output rec_t                   rec_o,
  output logic                   rec_valid_o
);

  localparam int unsigned CNT_W = $clog2(CONST_BYTES + 3);

  function automatic logic [CNT_W-1:0] instr_len(input logic [3:0] ic);
    logic [CNT_W-1:0] len;
    case (ic)
      IC_CMOV, IC_OP, IC_PUSH, IC_POP:   len = CNT_W'(2);
      IC_IRMOV, IC_RMMOV, IC_MRMOV:     len = CNT_W'(2 + CONST_BYTES);
      IC_JXX, IC_CALL:                  len = CNT_W'(1 + CONST_BYTES);
      default:                          len = CNT_W'(1);
    endcase
    return len;
  endfunction

  function automatic logic has_regbyte(input logic [3:0] ic);
    return (ic == IC_CMOV) || (ic == IC_IRMOV) || (ic == IC_RMMOV) ||
           (ic == IC_MRMOV) || (ic == IC_OP) || (ic == IC_PUSH) || (ic == IC_POP);
  endfunction

  function automatic logic check_valid(input logic [3:0] ic, input logic [3:0] fn);
    logic ok;
    ok = 1'b1;
    if (ic >= IC_FIRST_BAD) begin
      ok = 1'b0;
    end else if (((ic == IC_CMOV) || (ic == IC_OP) || (ic == IC_JXX)) && (fn > FUN_MAX)) begin
      ok = 1'b0;
    end
    return ok;
  endfunction

  logic [7:0]        opcode_q, opcode_d;
  logic [7:0]        regbyte_q, regbyte_d;
  logic [WORD_W-1:0] const_q, const_d;
  logic [CNT_W-1:0]  left_q, left_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [ADDR_W-1:0] next_addr_q, next_addr_d;
  logic [ADDR_W-1:0] start_addr_q;

  logic [3:0]        hold_ic;
  logic              hold_reg;
  logic [CNT_W-1:0]  k;
  logic [CNT_W-1:0]  new_len;
  logic [CNT_W-1:0]  emit_len;
  logic [7:0]        emit_op;
  logic [7:0]        emit_rb;
  logic [WORD_W-1:0] emit_k;

  assign hold_ic  = opcode_q[7:4];
  assign hold_reg = has_regbyte(hold_ic);
  assign k        = idx_q - (hold_reg ? CNT_W'(2) : CNT_W'(1));
  assign new_len  = instr_len(byte_i[7:4]);

  always_comb begin
    opcode_d    = opcode_q;
    regbyte_d   = regbyte_q;
    const_d     = const_q;
    left_d      = left_q;
    idx_d       = idx_q;
    next_addr_d = next_addr_q;
    rec_valid_o = 1'b0;
    emit_op     = byte_i;
    emit_rb     = REG_NONE;
    emit_k      = '0;
    emit_len    = CNT_W'(1);

    if (fire_i) begin
      if (left_q == '0) begin
        if (new_len == CNT_W'(1)) begin
          // Single-byte instruction, including unknown opcodes.
          rec_valid_o = 1'b1;
        end else begin
          opcode_d  = byte_i;
          regbyte_d = REG_NONE;
          const_d   = '0;
          left_d    = new_len - CNT_W'(1);
          idx_d     = CNT_W'(1);
        end
      end else begin
        if (hold_reg && (idx_q == CNT_W'(1))) begin
          regbyte_d = byte_i;
        end else if (k < CNT_W'(4)) begin
          const_d = const_q | (WORD_W'(byte_i) << {k[1:0], 3'b000});
        end
        left_d = left_q - CNT_W'(1);
        idx_d  = idx_q + CNT_W'(1);
        if (left_q == CNT_W'(1)) begin
          rec_valid_o = 1'b1;
          emit_op     = opcode_q;
          emit_rb     = regbyte_d;
          emit_k      = const_d;
          emit_len    = instr_len(hold_ic);
          idx_d       = '0;
        end
      end

      if (rec_valid_o) begin
        next_addr_d = next_addr_q + ADDR_W'(emit_len);
      end

      // End of image: drop any partial instruction and rearm for the next one.
      if (last_i) begin
        left_d      = '0;
        idx_d       = '0;
        regbyte_d   = REG_NONE;
        const_d     = '0;
        next_addr_d = start_addr_q;
      end
    end

    if (cfg_we_i && (left_d == '0)) begin
      next_addr_d = cfg_data_i;
    end
  end

  always_comb begin
    rec_o.instr_address = next_addr_q;
    rec_o.icode         = emit_op[7:4];
    rec_o.ifun          = emit_op[3:0];
    rec_o.reg_a         = emit_rb[7:4];
    rec_o.reg_b         = emit_rb[3:0];
    rec_o.constant_word = emit_k;
    rec_o.instr_length  = emit_len[LEN_W-1:0];
    rec_o.is_valid      = check_valid(emit_op[7:4], emit_op[3:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opcode_q     <= '0;
      regbyte_q    <= REG_NONE;
      const_q      <= '0;
      left_q       <= '0;
      idx_q        <= '0;
      next_addr_q  <= '0;
      start_addr_q <= '0;
    end else begin
      opcode_q    <= opcode_d;
      regbyte_q   <= regbyte_d;
      const_q     <= const_d;
      left_q      <= left_d;
      idx_q       <= idx_d;
      next_addr_q <= next_addr_d;
      if (cfg_we_i) begin
        start_addr_q <= cfg_data_i;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/y86bsd_out_reg.sv */
// Result register of the Y86 decoder: holds one record until the receiver takes it.
// Depends on y86bsd_pkg.
`default_nettype none

module y86bsd_out_reg
  import y86bsd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire rec_t rec_i,
  output logic      ready_o,
  output logic      valid_o,
  input  wire logic take_i,
  output rec_t      rec_o
);

  logic valid_q;
  rec_t rec_q;

  // Space is free when empty, or when the held record leaves this cycle.
  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign rec_o   = rec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && push_i) begin
      rec_q <= rec_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/y86_byte_stream_decoder.sv */
// Top level of the Y86 byte-stream decoder: stream ports and configuration port.
// Depends on y86bsd_pkg, y86bsd_assembler and y86bsd_out_reg.
//
// The block takes a Y86 machine-code image one byte per transfer on the slave
// stream (s_axis_tdata carries the byte, s_axis_tlast marks the last byte of the
// image) and produces one record per completed instruction on the master stream.
// A record carries the instruction's address, opcode nibbles, register nibbles,
// little-endian constant, length and a validity flag (in m_axis_tuser).
// One byte is taken per clock cycle when the output side keeps up. The record of
// an instruction appears on the master stream in the cycle after the transfer of
// its last byte. A single result register sits between the two sides. While it
// holds a record that the receiver does not take, every byte is refused; bytes
// are taken again in the cycle in which the held record is transferred, so a
// stall on the master side reaches the slave side in the same cycle.
// The start address is written through the cfg channel, which is always ready; a
// write while no instruction is being assembled also sets the address of the
// next instruction, otherwise it takes effect at the next end of image.
// Reset clears the assembly state, sets the start address to zero and empties
// the result register. At the end of an image a partial instruction is dropped.
`default_nettype none

module y86_byte_stream_decoder
  import y86bsd_pkg::*;
#(
  parameter int unsigned CONST_BYTES = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Byte stream in.
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [7:0]        s_axis_tdata,   // [7:0] code_byte
  input  wire logic              s_axis_tlast,
  // Record stream out.
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // [31:0] instr_address, [35:32] icode, [39:36] ifun, [43:40] reg_a,
  // [47:44] reg_b, [79:48] constant_word, [82:80] instr_length, rest zero
  output logic [87:0]            m_axis_tdata,
  output logic                   m_axis_tuser,   // [0] is_valid
  // Start address register write.
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [ADDR_W-1:0] cfg_data_i
);

  logic in_fire;
  logic rec_valid;
  rec_t rec;
  rec_t out_rec;

  assign in_fire     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  y86bsd_assembler #(
    .CONST_BYTES(CONST_BYTES)
  ) u_asm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (in_fire),
    .byte_i     (s_axis_tdata),
    .last_i     (s_axis_tlast),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .rec_o      (rec),
    .rec_valid_o(rec_valid)
  );

  y86bsd_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (rec_valid),
    .rec_i  (rec),
    .ready_o(s_axis_tready),
    .valid_o(m_axis_tvalid),
    .take_i (m_axis_tready),
    .rec_o  (out_rec)
  );

  assign m_axis_tdata = {5'b0, out_rec.instr_length, out_rec.constant_word,
                         out_rec.reg_b, out_rec.reg_a, out_rec.ifun,
                         out_rec.icode, out_rec.instr_address};
  assign m_axis_tuser = out_rec.is_valid;

endmodule

`default_nettype wire
